// ----- hw/rtl/lrtr_pkg.sv -----
// Shared types, constants and helpers for the log record time rewriter.
package lrtr_pkg;

  localparam logic [7:0]  TAG_RECORD = 8'h0A;
  localparam logic [7:0]  TAG_TIME   = 8'h08;
  localparam logic [31:0] TIME_MIN   = 32'd1263563523;
  localparam logic [2:0]  LEN_BYTES  = 3'd5;
  localparam logic [2:0]  TIME_BYTES = 3'd5;

  typedef enum logic [6:0] {
    PH_FIRST      = 7'b0000001,
    PH_LEN        = 7'b0000010,
    PH_BODY_FIRST = 7'b0000100,
    PH_TIME       = 7'b0001000,
    PH_SKIP       = 7'b0010000,
    PH_TAG        = 7'b0100000,
    PH_PASS       = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       rewritten;
  } result_t;

  // Five-byte varint form of the timestamp, one byte per index.
  function automatic logic [7:0] time_byte(input logic [31:0] t, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = {1'b1, t[6:0]};
      3'd1:    b = {1'b1, t[13:7]};
      3'd2:    b = {1'b1, t[20:14]};
      3'd3:    b = {1'b1, t[27:21]};
      default: b = {4'b0000, t[31:28]};
    endcase
    return b;
  endfunction

  // Place one length varint byte at its bit position.
  function automatic logic [31:0] len_part(input logic [7:0] b, input logic [2:0] cnt);
    logic [31:0] p;
    case (cnt)
      3'd0:    p = {25'd0, b[6:0]};
      3'd1:    p = {18'd0, b[6:0], 7'd0};
      3'd2:    p = {11'd0, b[6:0], 14'd0};
      3'd3:    p = {4'd0, b[6:0], 21'd0};
      default: p = {b[3:0], 28'd0};
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/lrtr_parser.sv -----
// Record parser: tracks the record structure and picks each output byte.
module lrtr_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       byte_in,
  input  logic             last_in,
  input  logic [31:0]      stamp_time,
  output lrtr_pkg::result_t res
);

  lrtr_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [2:0]  len_cnt_r, len_cnt_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [2:0]  tidx_r, tidx_nxt;
  logic [31:0] accum_or;
  logic [31:0] remain_dec;
  logic [2:0]  len_cnt_inc;
  logic [2:0]  tidx_inc;

  assign accum_or    = accum_r | lrtr_pkg::len_part(byte_in, len_cnt_r);
  assign remain_dec  = remain_r - 32'd1;
  assign len_cnt_inc = len_cnt_r + 3'd1;
  assign tidx_inc    = tidx_r + 3'd1;

  always_comb begin
    phase_nxt     = phase_r;
    accum_nxt     = accum_r;
    len_cnt_nxt   = len_cnt_r;
    remain_nxt    = remain_r;
    tidx_nxt      = tidx_r;
    res.data      = byte_in;
    res.rewritten = 1'b0;
    case (phase_r)
      lrtr_pkg::PH_FIRST, lrtr_pkg::PH_TAG: begin
        if (byte_in == lrtr_pkg::TAG_RECORD &&
            (phase_r == lrtr_pkg::PH_TAG || stamp_time >= lrtr_pkg::TIME_MIN)) begin
          accum_nxt   = '0;
          len_cnt_nxt = '0;
          phase_nxt   = lrtr_pkg::PH_LEN;
        end else begin
          phase_nxt = lrtr_pkg::PH_PASS;
        end
      end
      lrtr_pkg::PH_LEN: begin
        accum_nxt   = accum_or;
        len_cnt_nxt = len_cnt_inc;
        if (!byte_in[7]) begin
          remain_nxt = accum_or;
          phase_nxt  = (accum_or == '0) ? lrtr_pkg::PH_TAG : lrtr_pkg::PH_BODY_FIRST;
        end else if (len_cnt_inc >= lrtr_pkg::LEN_BYTES) begin
          // unterminated length: give up on this frame
          phase_nxt = lrtr_pkg::PH_PASS;
        end
      end
      lrtr_pkg::PH_BODY_FIRST: begin
        remain_nxt = remain_dec;
        if (byte_in == lrtr_pkg::TAG_TIME) begin
          tidx_nxt  = '0;
          phase_nxt = lrtr_pkg::PH_TIME;
        end else begin
          phase_nxt = lrtr_pkg::PH_SKIP;
        end
        if (remain_dec == '0) phase_nxt = lrtr_pkg::PH_TAG;
      end
      lrtr_pkg::PH_TIME: begin
        res.data      = lrtr_pkg::time_byte(stamp_time, tidx_r);
        res.rewritten = 1'b1;
        remain_nxt    = remain_dec;
        tidx_nxt      = tidx_inc;
        if (tidx_inc >= lrtr_pkg::TIME_BYTES) phase_nxt = lrtr_pkg::PH_SKIP;
        // short body drops the rest of the timestamp
        if (remain_dec == '0) phase_nxt = lrtr_pkg::PH_TAG;
      end
      lrtr_pkg::PH_SKIP: begin
        remain_nxt = remain_dec;
        if (remain_dec == '0) phase_nxt = lrtr_pkg::PH_TAG;
      end
      default: begin
        phase_nxt = lrtr_pkg::PH_PASS;
      end
    endcase
    if (last_in) begin
      phase_nxt   = lrtr_pkg::PH_FIRST;
      accum_nxt   = '0;
      len_cnt_nxt = '0;
      remain_nxt  = '0;
      tidx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lrtr_pkg::PH_FIRST;
      accum_r   <= '0;
      len_cnt_r <= '0;
      remain_r  <= '0;
      tidx_r    <= '0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      accum_r   <= accum_nxt;
      len_cnt_r <= len_cnt_nxt;
      remain_r  <= remain_nxt;
      tidx_r    <= tidx_nxt;
    end
  end

endmodule

// ----- hw/rtl/log_record_time_rewriter_unit.sv -----
// Top level of the log record time rewriter: config register, parser, output skid.
// Usage:
//   Input beats (in_byte, in_last) arrive on in_valid/in_stall; one result beat
//   (out_byte, out_last, out_rewritten) leaves per input beat on out_valid/out_stall.
//   A frame is a serialized log group; in_last marks its final byte. Records whose
//   body opens with the time field get their five timestamp bytes replaced by the
//   value in the configuration register; the user must write it with cfg_wr_en and
//   cfg_stamp_time only while the block is idle; the block does not enforce this.
//   Values below 1263563523 leave frames untouched.
// Throughput: one beat per cycle while in_stall is low; the parser registers each beat.
// Stall: an output register plus a one-entry skid stage hold up to two results,
//   so a beat is still taken in the cycle the receiver first stalls; in_stall
//   rises only once the skid entry is occupied, and drops when it drains.
// Reset: synchronous, active low; clears the parser to expect the first tag of a
//   new frame, empties both output entries and sets the timestamp register to 0.
module log_record_time_rewriter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_rewritten,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_stamp_time
);

  logic [31:0]       stamp_time_r;
  logic              in_acc;
  logic              out_take;
  lrtr_pkg::result_t res;

  logic              out_v_r;
  lrtr_pkg::result_t out_res_r;
  logic              out_last_r;
  logic              skid_v_r;
  lrtr_pkg::result_t skid_res_r;
  logic              skid_last_r;

  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !skid_v_r;
  assign out_take = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_time_r <= '0;
    end else if (cfg_wr_en) begin
      stamp_time_r <= cfg_stamp_time;
    end
  end

  lrtr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .byte_in    (in_byte),
    .last_in    (in_last),
    .stamp_time (stamp_time_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      // drain the skid entry into the output register
      if (out_take) begin
        out_res_r  <= skid_res_r;
        out_last_r <= skid_last_r;
        skid_v_r   <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_v_r || out_take) begin
        out_res_r  <= res;
        out_last_r <= in_last;
        out_v_r    <= 1'b1;
      end else begin
        skid_res_r  <= res;
        skid_last_r <= in_last;
        skid_v_r    <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_valid     = out_v_r;
  assign out_byte      = out_res_r.data;
  assign out_rewritten = out_res_r.rewritten;
  assign out_last      = out_last_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while output register empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && out_v_r && out_stall) |=> skid_v_r)
    else $error("beat accepted under stall was not held in skid");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!out_v_r && !skid_v_r))
    else $error("output entries not empty after reset");

endmodule

// ----- tb/log_record_time_rewriter_unit_tb.sv -----
// Testbench for the log record time rewriter: frame stimulus, timestamp predictor, checks.
`timescale 1ns / 100ps

module log_record_time_rewriter_unit_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       rewritten;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_rewritten;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_stamp_time = 32'd0;

  // Stimulus and scoreboard state
  in_beat_t    frame_feed[$];
  logic [7:0]  frame_q[$];
  out_beat_t   predicted_beats[$];
  int          beats_queued = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;
  int          src_gap = 0;
  int          snk_wait = 0;
  int          hold_requests = 0;
  int          holds_done = 0;
  int          hold_left = 0;

  // Predictor state
  lrtr_pkg::phase_t parse_ph = lrtr_pkg::PH_FIRST;
  logic [31:0] len_acc = '0;
  logic [2:0]  len_cnt = '0;
  logic [31:0] body_left = '0;
  logic [2:0]  stamp_idx = '0;
  logic [31:0] stamp = '0;

  log_record_time_rewriter_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_rewritten  (out_rewritten),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_stamp_time (cfg_stamp_time)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(300_000 * 12);
    $display("FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_parse();
    parse_ph = lrtr_pkg::PH_FIRST;
    len_acc = '0;
    len_cnt = '0;
    body_left = '0;
    stamp_idx = '0;
  endfunction

  function automatic void open_length();
    len_acc = '0;
    len_cnt = '0;
    parse_ph = lrtr_pkg::PH_LEN;
  endfunction

  // Advance the parser by one byte and return the beat it should emit.
  function automatic out_beat_t rewrite_step(input logic [7:0] b, input logic last);
    out_beat_t   r;
    logic [31:0] sh;
    r.data = b;
    r.last = last;
    r.rewritten = 1'b0;
    case (parse_ph)
      lrtr_pkg::PH_FIRST: begin
        if (stamp >= lrtr_pkg::TIME_MIN && b == lrtr_pkg::TAG_RECORD) open_length();
        else parse_ph = lrtr_pkg::PH_PASS;
      end
      lrtr_pkg::PH_TAG: begin
        if (b == lrtr_pkg::TAG_RECORD) open_length();
        else parse_ph = lrtr_pkg::PH_PASS;
      end
      lrtr_pkg::PH_LEN: begin
        // fifth byte: keep only the low nibble as bits 31..28
        if (len_cnt >= lrtr_pkg::LEN_BYTES - 1) len_acc = len_acc | {b[3:0], 28'd0};
        else len_acc = len_acc | (32'(b[6:0]) << (7 * len_cnt));
        len_cnt = len_cnt + 3'd1;
        if (!b[7]) begin
          body_left = len_acc;
          if (len_acc == 0) parse_ph = lrtr_pkg::PH_TAG;
          else parse_ph = lrtr_pkg::PH_BODY_FIRST;
        end else if (len_cnt >= lrtr_pkg::LEN_BYTES) begin
          parse_ph = lrtr_pkg::PH_PASS;
        end
      end
      lrtr_pkg::PH_BODY_FIRST: begin
        body_left = body_left - 1;
        if (b == lrtr_pkg::TAG_TIME) begin
          stamp_idx = '0;
          parse_ph = lrtr_pkg::PH_TIME;
        end else begin
          parse_ph = lrtr_pkg::PH_SKIP;
        end
        if (body_left == 0) parse_ph = lrtr_pkg::PH_TAG;
      end
      lrtr_pkg::PH_TIME: begin
        sh = stamp >> (7 * stamp_idx);
        if (stamp_idx >= lrtr_pkg::TIME_BYTES - 1) r.data = {4'b0000, stamp[31:28]};
        else r.data = {1'b1, sh[6:0]};
        r.rewritten = 1'b1;
        body_left = body_left - 1;
        stamp_idx = stamp_idx + 3'd1;
        if (stamp_idx >= lrtr_pkg::TIME_BYTES) parse_ph = lrtr_pkg::PH_SKIP;
        if (body_left == 0) parse_ph = lrtr_pkg::PH_TAG;
      end
      lrtr_pkg::PH_SKIP: begin
        body_left = body_left - 1;
        if (body_left == 0) parse_ph = lrtr_pkg::PH_TAG;
      end
      default: parse_ph = lrtr_pkg::PH_PASS;
    endcase
    if (last) clear_parse();
    return r;
  endfunction

  // Input side: present the next queued byte once the gap has run out.
  always @(negedge clk) begin : driver
    in_beat_t nb;
    if (rst_n && (!in_valid || in_fire)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (frame_feed.size() > 0) begin
        nb = frame_feed.pop_front();
        in_byte <= nb.data;
        in_last <= nb.last;
        in_valid <= 1'b1;
        src_gap = src_idle_en ? $urandom_range(0, 8) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random stall per beat, plus long holds on request.
  always @(negedge clk) begin : sink
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (holds_done < hold_requests) begin
        holds_done++;
        hold_left = 59;
        out_stall <= 1'b1;
      end else begin
        if (out_fire) snk_wait = snk_idle_en ? $urandom_range(0, 8) : 0;
        if (snk_wait > 0) begin
          snk_wait--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Check results against the oldest prediction, then predict accepted beats.
  always @(posedge clk) begin : monitor
    out_beat_t got;
    out_beat_t want;
    in_fire = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (!rst_n) begin
      clear_parse();
      stamp = '0;
      predicted_beats.delete();
    end else begin
      if (out_fire) begin
        results_seen++;
        got = '{out_byte, out_last, out_rewritten};
        if (predicted_beats.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat %02h", out_byte));
        end else begin
          want = predicted_beats.pop_front();
          if (got.data !== want.data)
            flag_mismatch($sformatf("byte got %02h want %02h", got.data, want.data));
          if (got.last !== want.last)
            flag_mismatch($sformatf("last got %b want %b", got.last, want.last));
          if (got.rewritten !== want.rewritten)
            flag_mismatch($sformatf("rewritten got %b want %b (byte %02h)",
                                    got.rewritten, want.rewritten, want.data));
        end
      end
      if (in_fire) predicted_beats.push_back(rewrite_step(in_byte, in_last));
      if (cfg_wr_en) stamp = cfg_stamp_time;
    end
  end

  task automatic settle();
    while (results_seen < beats_queued) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_time(input logic [31:0] v);
    @(negedge clk);
    cfg_stamp_time <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Queue the built bytes; mark the final one when the frame closes.
  task automatic send_frame(input bit close);
    int n;
    n = frame_q.size();
    for (int i = 0; i < n; i++) frame_feed.push_back('{frame_q[i], close && (i == n - 1)});
    beats_queued += n;
    frame_q.delete();
  endtask

  task automatic add_length(input logic [31:0] len);
    logic [7:0] v;
    if ($urandom_range(0, 9) < 7) begin
      do begin
        v = {1'b0, len[6:0]};
        len = len >> 7;
        if (len != 0) v[7] = 1'b1;
        frame_q.push_back(v);
      end while (len != 0);
    end else begin
      // padded to five bytes, junk in the spare bits of the last one
      for (int i = 0; i < 4; i++) frame_q.push_back({1'b1, 7'(len >> (7 * i))});
      frame_q.push_back({1'b0, 3'($urandom), len[31:28]});
    end
  endtask

  // Append one record; open_ended is set when nothing may follow it.
  task automatic add_record(output bit open_ended);
    int          sel;
    int          n;
    logic [31:0] len;
    bit          stamped;
    sel = $urandom_range(0, 99);
    stamped = $urandom_range(0, 3) != 0;
    open_ended = 1'b0;
    frame_q.push_back(lrtr_pkg::TAG_RECORD);
    if (sel >= 95) begin
      for (int i = 0; i < 5; i++) frame_q.push_back({1'b1, 7'($urandom)});
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom));
      open_ended = 1'b1;
    end else begin
      if (sel < 10) len = 0;
      else if (sel < 35) len = $urandom_range(1, 5);
      else if (sel < 88) len = $urandom_range(6, 14);
      else len = $urandom;
      add_length(len);
      n = len;
      if (len > 20) begin
        n = $urandom_range(0, 12);
        open_ended = 1'b1;
      end
      for (int i = 0; i < n; i++)
        frame_q.push_back((i == 0 && stamped) ? lrtr_pkg::TAG_TIME : 8'($urandom));
    end
  endtask

  task automatic gen_frame();
    int         n;
    bit         open_ended;
    logic [7:0] v;
    if ($urandom_range(0, 99) < 10) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      open_ended = 1'b0;
      for (int i = 0; i < n && !open_ended; i++) add_record(open_ended);
      if (!open_ended && $urandom_range(0, 4) == 0) begin
        // stray byte at a record boundary; anything after it passes as is
        do v = 8'($urandom); while (v == lrtr_pkg::TAG_RECORD);
        frame_q.push_back(v);
        if ($urandom_range(0, 1) == 0) begin
          frame_q.push_back(lrtr_pkg::TAG_RECORD);
          frame_q.push_back(8'h01);
          frame_q.push_back(lrtr_pkg::TAG_TIME);
        end
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom));
      end
    end
    // cut some frames short
    if ($urandom_range(0, 9) == 0 && frame_q.size() > 1)
      while (frame_q.size() > 1 && $urandom_range(0, 2) != 0) void'(frame_q.pop_back());
    send_frame(1'b1);
  endtask

  initial begin : stimulus
    logic [31:0] t;
    int          start;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // just below the threshold: whole frame passes
    set_time(lrtr_pkg::TIME_MIN - 1);
    frame_q = '{lrtr_pkg::TAG_RECORD, 8'h01, lrtr_pkg::TAG_TIME};
    send_frame(1'b1);
    settle();

    set_time(lrtr_pkg::TIME_MIN);
    // full stamp, then an empty body, then a stray byte at the boundary
    frame_q = '{lrtr_pkg::TAG_RECORD, 8'h06, lrtr_pkg::TAG_TIME, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, lrtr_pkg::TAG_RECORD, 8'h00, 8'h33};
    send_frame(1'b1);
    // frame not opening with a record tag
    frame_q = '{8'h5A, lrtr_pkg::TAG_RECORD, 8'h01, lrtr_pkg::TAG_TIME};
    send_frame(1'b1);
    settle();

    set_time(32'hFFFF_FFFF);
    // length never terminated
    frame_q = '{lrtr_pkg::TAG_RECORD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                lrtr_pkg::TAG_RECORD, 8'h03, lrtr_pkg::TAG_TIME};
    send_frame(1'b1);
    // five-byte length with junk upper bits, short body, then a new record
    frame_q = '{lrtr_pkg::TAG_RECORD, 8'h83, 8'h80, 8'h80, 8'h80, 8'h70,
                lrtr_pkg::TAG_TIME, 8'h12, 8'h34, lrtr_pkg::TAG_RECORD};
    send_frame(1'b1);
    // change the time in the middle of a stamp
    frame_q = '{lrtr_pkg::TAG_RECORD, 8'h07, lrtr_pkg::TAG_TIME, 8'h5A, 8'h5A};
    send_frame(1'b0);
    settle();
    set_time(32'h1234_5678);
    frame_q = '{8'hA5, 8'hA5, 8'hA5, 8'h99, 8'hEE};
    send_frame(1'b1);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0, 6: t = $urandom_range(32'hFFFF_FFFF, lrtr_pkg::TIME_MIN);
        1: t = 32'hFFFF_FFFF;
        2: t = lrtr_pkg::TIME_MIN;
        3: t = 32'd0;
        4: t = $urandom_range(lrtr_pkg::TIME_MIN - 1, 0);
        5: t = $urandom;
        default: t = lrtr_pkg::TIME_MIN - 1;
      endcase
      set_time(t);
      src_idle_en = (p % 3) != 1;
      snk_idle_en = (p % 4) != 1;
      start = beats_queued;
      while (beats_queued - start < 40) gen_frame();
      // hold the output while the input keeps coming
      if (p == 1) hold_requests++;
      settle();
    end

    settle();
    repeat (4) @(negedge clk);
    if (predicted_beats.size() != 0)
      flag_mismatch($sformatf("%0d beats never came out", predicted_beats.size()));
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
